>>> rtl/core/bdct_pkg.sv
// Shared types, register indexes, reset values and constant-divide helpers
// for the battery discharge capacity tester. No dependencies.

package bdct_pkg;

	// Transfer kinds on the command channel
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_POLL = 1'b1;

	// Configuration register indexes
	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
	localparam logic [2:0] REG_PRESENT       = 3'd1;
	localparam logic [2:0] REG_REMOVED       = 3'd2;
	localparam logic [2:0] REG_UNLOADED_MIN  = 3'd3;
	localparam logic [2:0] REG_DROP_STEP     = 3'd4;
	localparam logic [2:0] REG_DROP_COUNT    = 3'd5;
	localparam logic [2:0] REG_DROP_CEILING  = 3'd6;
	localparam logic [2:0] REG_EMPTY         = 3'd7;

	// Reset values of the configuration registers
	localparam logic [31:0] RST_SAMPLE_PERIOD = 32'd60000;
	localparam logic [12:0] RST_PRESENT       = 13'd1100;
	localparam logic [12:0] RST_REMOVED       = 13'd100;
	localparam logic [12:0] RST_UNLOADED_MIN  = 13'd850;
	localparam logic [12:0] RST_DROP_STEP     = 13'd15;
	localparam logic [3:0]  RST_DROP_COUNT    = 4'd3;
	localparam logic [12:0] RST_DROP_CEILING  = 13'd1000;
	localparam logic [12:0] RST_EMPTY         = 13'd10;

	// Saturated accumulator 0xFFFFFFFF split as quotient and remainder by 60
	localparam logic [26:0] CAP_SAT  = 27'd71582788;
	localparam logic [5:0]  REM_SAT  = 6'd15;
	localparam logic [3:0]  RUN_MAX  = 4'd15;
	localparam logic [11:0] MIN_PER_HOUR = 12'd60;

	// Reciprocals for the constant divides
	localparam logic [16:0] RECIP_33  = 17'd127101; // 2^22 / 33, rounded up
	localparam logic [12:0] RECIP_100 = 13'd5243;   // 2^19 / 100, rounded up
	localparam logic [11:0] RECIP_60  = 12'd2185;   // 2^17 / 60, rounded up

	typedef enum logic [1:0] {
		PH_INITIAL     = 2'd0,
		PH_IDLE        = 2'd1,
		PH_DISCHARGING = 2'd2,
		PH_ENDED       = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_START  = 3'd1,
		EV_RESUME = 3'd2,
		EV_SAMPLE = 3'd3,
		EV_END    = 3'd4,
		EV_WAIT   = 3'd5
	} event_t;

	typedef struct packed {
		logic        kind;
		logic [12:0] first_mv;
		logic [12:0] second_mv;
	} cmd_item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [1:0]  phase;
		logic        load_on;
		logic [11:0] current_ma;
		logic [26:0] capacity_mah;
		logic [12:0] loaded_mv;
		logic [12:0] unloaded_mv;
		logic [31:0] elapsed_ms;
		logic [4:0]  blink_count;
		logic        green_on;
		logic        red_blinking;
	} res_item_t;

	typedef struct packed {
		logic [31:0] sample_period_ms;
		logic [12:0] present_mv;
		logic [12:0] removed_mv;
		logic [12:0] unloaded_min_mv;
		logic [12:0] drop_step_mv;
		logic [3:0]  drop_count;
		logic [12:0] drop_ceiling_mv;
		logic [12:0] empty_mv;
	} cfg_t;

	// Registered command with both current estimates precomputed
	typedef struct packed {
		cmd_item_t   item;
		logic [11:0] cur_first;
		logic [11:0] cur_second;
	} stage_t;

	// mv * 10 / 33, exact for every 13-bit reading
	function automatic logic [11:0] est_current(input logic [12:0] mv);
		logic [16:0] x;
		logic [33:0] prod;
		x = {1'b0, mv, 3'b000} + {3'b000, mv, 1'b0};
		prod = {17'd0, x} * {17'd0, RECIP_33};
		return prod[33:22];
	endfunction

	// cur / 100, exact for cur below 3200
	function automatic logic [4:0] blink_of(input logic [11:0] cur);
		logic [24:0] prod;
		prod = {13'd0, cur} * {12'd0, RECIP_100};
		return prod[23:19];
	endfunction

	// s / 60, exact for s below 3840
	function automatic logic [5:0] div60(input logic [11:0] s);
		logic [23:0] prod;
		prod = {12'd0, s} * {12'd0, RECIP_60};
		return prod[22:17];
	endfunction

endpackage

>>> rtl/core/battery_discharge_capacity_tester.sv
// Battery discharge capacity tester: one tick or poll transfer is taken per
// clock while cmd_stall is low; each tick advances the millisecond clock and
// returns nothing, each poll returns exactly one result. A transfer is held
// in the input register, where both current estimates are formed; a poll's
// result is loaded into the output register once that register is free and
// is offered there until taken. The sustained rate is one item per cycle
// while the result side does not stall, set by the single state update
// between the input and output registers; a stall on the result side holds
// one result and one poll command.
// Depends on bdct_pkg, bdct_cfg, bdct_in_stage and bdct_engine.

module battery_discharge_capacity_tester import bdct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_item_t   cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output res_item_t   res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t      cfg;
	logic      valid_s1;
	stage_t    stage_s1;
	logic      adv;
	logic      res_load;
	res_item_t result;
	logic      res_valid_q;
	res_item_t res_q;
	logic      out_free;

	assign out_free = !res_valid_q || !res_stall;

	bdct_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bdct_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.stage_s1  (stage_s1)
	);

	bdct_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1),
		.out_free (out_free),
		.adv      (adv),
		.res_load (res_load),
		.result   (result)
	);

	// Output register: load a new result or drop the one just transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> rtl/core/bdct_cfg.sv
// Configuration register file for the discharge tester.
// Depends on bdct_pkg for the register indexes, reset values and cfg_t.

module bdct_cfg import bdct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_period_ms <= RST_SAMPLE_PERIOD;
			cfg_q.present_mv       <= RST_PRESENT;
			cfg_q.removed_mv       <= RST_REMOVED;
			cfg_q.unloaded_min_mv  <= RST_UNLOADED_MIN;
			cfg_q.drop_step_mv     <= RST_DROP_STEP;
			cfg_q.drop_count       <= RST_DROP_COUNT;
			cfg_q.drop_ceiling_mv  <= RST_DROP_CEILING;
			cfg_q.empty_mv         <= RST_EMPTY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_PERIOD: cfg_q.sample_period_ms <= cfg_data;
				REG_PRESENT:       cfg_q.present_mv       <= cfg_data[12:0];
				REG_REMOVED:       cfg_q.removed_mv       <= cfg_data[12:0];
				REG_UNLOADED_MIN:  cfg_q.unloaded_min_mv  <= cfg_data[12:0];
				REG_DROP_STEP:     cfg_q.drop_step_mv     <= cfg_data[12:0];
				REG_DROP_COUNT:    cfg_q.drop_count       <= cfg_data[3:0];
				REG_DROP_CEILING:  cfg_q.drop_ceiling_mv  <= cfg_data[12:0];
				REG_EMPTY:         cfg_q.empty_mv         <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/bdct_in_stage.sv
// Input register of the discharge tester: holds one command and the current
// estimates of both readings. Depends on bdct_pkg.

module bdct_in_stage import bdct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd,
	input  logic      adv,
	output logic      valid_s1,
	output stage_t    stage_s1
);

	logic take;

	// Take a new command when the register is empty or the held command moves on this cycle
	assign cmd_stall = valid_s1 && !adv;
	assign take      = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			stage_s1.item       <= cmd;
			stage_s1.cur_first  <= est_current(cmd.first_mv);
			stage_s1.cur_second <= est_current(cmd.second_mv);
		end
	end

endmodule

>>> rtl/core/bdct_engine.sv
// Phase machine, millisecond clock and capacity accumulator of the tester.
// Works on the registered command; depends on bdct_pkg.

module bdct_engine import bdct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      valid_s1,
	input  stage_t    stage_s1,
	input  logic      out_free,
	output logic      adv,
	output logic      res_load,
	output res_item_t result
);

	phase_t      phase_q, phase_d;
	logic [31:0] clock_q, start_q, start_d, next_q, next_d;
	logic [31:0] charge_q, charge_d;
	logic [26:0] cap_q, cap_d;
	logic [5:0]  rem_q, rem_d;
	logic [12:0] last_q, last_d;
	logic [3:0]  run_q, run_d;
	logic        load_q, load_d;

	logic        is_poll;
	logic [12:0] first_mv, second_mv;
	logic [31:0] due_diff;
	logic        sample_due;
	logic        sat;
	logic [11:0] acc_sum;
	logic [5:0]  acc_quo;
	logic [11:0] acc_rem;
	logic [13:0] drop;
	logic        large_drop;
	logic [3:0]  run_inc;

	event_t      ev;
	logic        report;
	logic [11:0] cur;
	logic [12:0] lmv, umv;

	assign is_poll   = stage_s1.item.kind == KIND_POLL;
	assign first_mv  = stage_s1.item.first_mv;
	assign second_mv = stage_s1.item.second_mv;
	assign adv       = valid_s1 && (!is_poll || out_free);
	assign res_load  = adv && is_poll;

	// Sample arithmetic, used only on the sample path
	assign due_diff   = clock_q - next_q;
	assign sample_due = (due_diff != 32'd0) && !due_diff[31];
	assign sat        = charge_q > (32'hFFFF_FFFF - {20'd0, stage_s1.cur_first});
	assign acc_sum    = {6'd0, rem_q} + stage_s1.cur_first;
	assign acc_quo    = div60(acc_sum);
	assign acc_rem    = acc_sum - ({6'd0, acc_quo} * MIN_PER_HOUR);
	assign drop       = {1'b0, last_q} - {1'b0, first_mv};
	assign large_drop = !drop[13] && (drop[12:0] > cfg.drop_step_mv);
	assign run_inc    = (run_q == RUN_MAX) ? RUN_MAX : run_q + 4'd1;

	always_comb begin
		phase_d  = phase_q;
		start_d  = start_q;
		next_d   = next_q;
		charge_d = charge_q;
		cap_d    = cap_q;
		rem_d    = rem_q;
		last_d   = last_q;
		run_d    = run_q;
		load_d   = load_q;
		ev       = EV_NONE;
		report   = 1'b0;
		cur      = 12'd0;
		lmv      = 13'd0;
		umv      = 13'd0;

		unique case (phase_q)
			PH_INITIAL, PH_IDLE: begin
				if (first_mv > cfg.present_mv) begin
					ev       = (phase_q == PH_INITIAL) ? EV_RESUME : EV_START;
					report   = 1'b1;
					lmv      = second_mv;
					umv      = first_mv;
					cur      = stage_s1.cur_second;
					phase_d  = PH_DISCHARGING;
					load_d   = 1'b1;
					start_d  = clock_q;
					charge_d = 32'd0;
					cap_d    = 27'd0;
					rem_d    = 6'd0;
					last_d   = 13'd0;
					run_d    = 4'd0;
					next_d   = clock_q + cfg.sample_period_ms;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_DISCHARGING: begin
				if (first_mv < cfg.removed_mv) begin
					ev      = EV_END;
					phase_d = PH_ENDED;
					load_d  = 1'b0;
				end else if (sample_due) begin
					ev       = EV_SAMPLE;
					report   = 1'b1;
					lmv      = first_mv;
					umv      = second_mv;
					cur      = stage_s1.cur_first;
					charge_d = sat ? 32'hFFFF_FFFF : charge_q + {20'd0, stage_s1.cur_first};
					cap_d    = sat ? CAP_SAT : cap_q + {21'd0, acc_quo};
					rem_d    = sat ? REM_SAT : acc_rem[5:0];
					next_d   = next_q + cfg.sample_period_ms;
					// Low unloaded voltage ends the run before the drop tracker moves
					if (second_mv < cfg.unloaded_min_mv) begin
						phase_d = PH_ENDED;
						load_d  = 1'b0;
					end else begin
						last_d = first_mv;
						run_d  = large_drop ? run_inc : 4'd0;
						if ((run_d >= cfg.drop_count) && (first_mv < cfg.drop_ceiling_mv)) begin
							phase_d = PH_ENDED;
							load_d  = 1'b0;
						end else begin
							load_d = 1'b1;
						end
					end
				end
			end
			PH_ENDED: begin
				if (first_mv < cfg.empty_mv) begin
					ev      = EV_WAIT;
					phase_d = PH_IDLE;
				end
			end
			default: ;
		endcase

		result.event_res    = ev;
		result.phase        = phase_d;
		result.load_on      = load_d;
		result.current_ma   = cur;
		result.capacity_mah = cap_d;
		result.loaded_mv    = lmv;
		result.unloaded_mv  = umv;
		result.elapsed_ms   = (ev == EV_START || ev == EV_RESUME || ev == EV_SAMPLE ||
			ev == EV_END) ? clock_q - start_d : 32'd0;
		result.blink_count  = report ? blink_of(cur) : 5'd0;
		result.green_on     = (phase_d == PH_IDLE) || (phase_d == PH_ENDED);
		result.red_blinking = phase_d == PH_DISCHARGING;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_INITIAL;
			clock_q  <= 32'd0;
			start_q  <= 32'd0;
			next_q   <= 32'd0;
			charge_q <= 32'd0;
			cap_q    <= 27'd0;
			rem_q    <= 6'd0;
			last_q   <= 13'd0;
			run_q    <= 4'd0;
			load_q   <= 1'b0;
		end else if (adv) begin
			if (!is_poll) begin
				clock_q <= clock_q + 32'd1;
			end else begin
				phase_q  <= phase_d;
				start_q  <= start_d;
				next_q   <= next_d;
				charge_q <= charge_d;
				cap_q    <= cap_d;
				rem_q    <= rem_d;
				last_q   <= last_d;
				run_q    <= run_d;
				load_q   <= load_d;
			end
		end
	end

	a_load_follows_phase: assert property (@(posedge clk) disable iff (!arst_n)
		load_q == (phase_q == PH_DISCHARGING))
		else $error("load state disagrees with phase");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < 6'd60)
		else $error("capacity remainder out of range");

	a_cap_matches_charge: assert property (@(posedge clk) disable iff (!arst_n)
		({5'd0, cap_q} * 32'd60 + {26'd0, rem_q}) == charge_q)
		else $error("capacity split disagrees with accumulator");

	a_tick_advances_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !is_poll) |=> clock_q == $past(clock_q) + 32'd1)
		else $error("tick did not advance the millisecond clock");

endmodule
